### rtl/pcib_pkg.sv
// ----------------------------------------------------------------------------
// pcib_pkg
// Shared constants and types for the positional character insert buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcib_pkg;

  // store geometry
  localparam int unsigned CAPACITY = 4096;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned LEN_W    = $clog2(CAPACITY + 1);

  // item field widths
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LENO_W   = 16;

  // operation codes
  localparam logic [FUNC_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [FUNC_W-1:0] OP_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] OP_QUERY  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [LEN_W-1:0]  len_t;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SHIFT  = 5'b00010,
    S_PLACE  = 5'b00100,
    S_READ   = 5'b01000,
    S_RESULT = 5'b10000
  } state_e;

endpackage

### rtl/pcib_if.sv
// ----------------------------------------------------------------------------
// pcib_if
// Valid/ready channels carrying request and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pcib_req_if;
  logic                            valid;
  logic                            ready;
  logic [pcib_pkg::FUNC_W-1:0]     func;
  logic [pcib_pkg::CHAR_W-1:0]     char_in;
  logic [pcib_pkg::POS_W-1:0]      position;

  modport source (output valid, func, char_in, position, input ready);
  modport sink   (input valid, func, char_in, position, output ready);
endinterface

interface pcib_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [pcib_pkg::CHAR_W-1:0]     char_out;
  logic [pcib_pkg::STATUS_W-1:0]   status;
  logic [pcib_pkg::LENO_W-1:0]     length_now;

  modport source (output valid, char_out, status, length_now, input ready);
  modport sink   (input valid, char_out, status, length_now, output ready);
endinterface

### rtl/positional_char_insert_query_buffer_unit.sv
// ----------------------------------------------------------------------------
// positional_char_insert_query_buffer_unit
// Character buffer with append, insert at position and query at position.
// ----------------------------------------------------------------------------
//  channel  | dir | fields                          | handshake
//  req_i    | in  | func, char_in, position         | valid/ready
//  rsp_o    | out | char_out, status, length_now    | valid/ready
//
//  an insert passes idle, shift, place and result; in shift one store element
//  is moved per cycle through the single read and single write port of the
//  text memory; a load passes idle, shift, place and result, a query idle,
//  read and result, a rejected or unused item idle and result; one item is
//  in work at a time; req_i.ready is low until its result sits in the output
//  register, which may wait for rsp_o.ready while the next item is taken;
//  reset clears the control registers only, the memory needs no clearing
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_char_insert_query_buffer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  pcib_req_if.sink    req_i,
  pcib_rsp_if.source  rsp_o
);

  // text memory
  logic [pcib_pkg::CHAR_W-1:0] mem [pcib_pkg::CAPACITY];
  logic [pcib_pkg::CHAR_W-1:0] mem_rdata_q;
  pcib_pkg::addr_t             rd_addr;
  pcib_pkg::addr_t             wr_addr;
  logic [pcib_pkg::CHAR_W-1:0] wr_data;
  logic                        wr_en;

  // sequencer state
  pcib_pkg::state_e            state_q, state_d;
  pcib_pkg::len_t              len_q, len_d;
  pcib_pkg::addr_t             idx_q, idx_d;
  pcib_pkg::addr_t             slot_q, slot_d;
  logic [pcib_pkg::CHAR_W-1:0] ch_q, ch_d;
  logic                        pend_q, pend_d;
  pcib_pkg::addr_t             pend_addr_q, pend_addr_d;
  logic [pcib_pkg::CHAR_W-1:0] res_char_q, res_char_d;
  logic [pcib_pkg::STATUS_W-1:0] res_st_q, res_st_d;

  // output register
  logic                          out_valid_q, out_valid_d;
  logic [pcib_pkg::CHAR_W-1:0]   out_char_q, out_char_d;
  logic [pcib_pkg::STATUS_W-1:0] out_st_q, out_st_d;
  logic [pcib_pkg::LENO_W-1:0]   out_len_q, out_len_d;

  // request decode
  logic                        accept;
  logic                        is_write;
  logic                        is_query;
  logic                        full;
  logic [pcib_pkg::POS_W-1:0]  len_ext;
  logic [pcib_pkg::POS_W-1:0]  pos_m1;
  logic                        pos_zero;
  logic                        pos_beyond;
  logic                        out_free;

  assign accept     = req_i.valid && req_i.ready;
  assign is_write   = (req_i.func == pcib_pkg::OP_LOAD) || (req_i.func == pcib_pkg::OP_INSERT);
  assign is_query   = (req_i.func == pcib_pkg::OP_QUERY);
  assign full       = (len_q == pcib_pkg::len_t'(pcib_pkg::CAPACITY));
  assign len_ext    = pcib_pkg::POS_W'(len_q);
  assign pos_m1     = req_i.position - 1'b1;
  assign pos_zero   = (req_i.position == '0);
  assign pos_beyond = (req_i.position > len_ext);
  assign out_free   = !out_valid_q || rsp_o.ready;

  assign req_i.ready = (state_q == pcib_pkg::S_IDLE);

  // sequencer
  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    idx_d       = idx_q;
    slot_d      = slot_q;
    ch_d        = ch_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    res_char_d  = res_char_q;
    res_st_d    = res_st_q;
    rd_addr     = idx_q - 1'b1;
    wr_addr     = pend_addr_q;
    wr_data     = mem_rdata_q;
    wr_en       = 1'b0;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_char_d  = out_char_q;
    out_st_d    = out_st_q;
    out_len_d   = out_len_q;

    unique case (state_q)
      pcib_pkg::S_IDLE: begin
        rd_addr = pos_m1[pcib_pkg::ADDR_W-1:0];
        if (accept) begin
          res_char_d = '0;
          res_st_d   = pcib_pkg::STATUS_OK;
          ch_d       = req_i.char_in;
          idx_d      = len_q[pcib_pkg::ADDR_W-1:0];
          if (is_write) begin
            if (full) begin
              res_st_d = pcib_pkg::STATUS_FULL;
              state_d  = pcib_pkg::S_RESULT;
            end else begin
              // append for load, past the end, or the chosen place
              if ((req_i.func == pcib_pkg::OP_LOAD) || pos_beyond) begin
                slot_d = len_q[pcib_pkg::ADDR_W-1:0];
              end else if (pos_zero) begin
                slot_d = '0;
              end else begin
                slot_d = pos_m1[pcib_pkg::ADDR_W-1:0];
              end
              state_d = pcib_pkg::S_SHIFT;
            end
          end else if (is_query) begin
            if (pos_zero || pos_beyond) begin
              res_st_d = pcib_pkg::STATUS_RANGE;
              state_d  = pcib_pkg::S_RESULT;
            end else begin
              state_d = pcib_pkg::S_READ;
            end
          end else begin
            state_d = pcib_pkg::S_RESULT;
          end
        end
      end
      pcib_pkg::S_SHIFT: begin
        // write back the element read last cycle one place up
        wr_en = pend_q;
        if (idx_q != slot_q) begin
          pend_d      = 1'b1;
          pend_addr_d = idx_q;
          idx_d       = idx_q - 1'b1;
        end else begin
          state_d = pcib_pkg::S_PLACE;
        end
      end
      pcib_pkg::S_PLACE: begin
        wr_en   = 1'b1;
        wr_addr = slot_q;
        wr_data = ch_q;
        len_d   = len_q + 1'b1;
        state_d = pcib_pkg::S_RESULT;
      end
      pcib_pkg::S_READ: begin
        res_char_d = mem_rdata_q;
        state_d    = pcib_pkg::S_RESULT;
      end
      pcib_pkg::S_RESULT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = res_char_q;
          out_st_d    = res_st_q;
          out_len_d   = pcib_pkg::LENO_W'(len_q);
          state_d     = pcib_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = pcib_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pcib_pkg::S_IDLE;
      len_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    slot_q      <= slot_d;
    ch_q        <= ch_d;
    pend_addr_q <= pend_addr_d;
    res_char_q  <= res_char_d;
    res_st_q    <= res_st_d;
    out_char_q  <= out_char_d;
    out_st_q    <= out_st_d;
    out_len_q   <= out_len_d;
  end

  // text memory ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_rdata_q <= mem[rd_addr];
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.char_out   = out_char_q;
  assign rsp_o.status     = out_st_q;
  assign rsp_o.length_now = out_len_q;

endmodule
